// File: sv/esrl_pkg.sv
// esrl_pkg: widths, escape codes and shared types of the escaped serial register loader
// no dependencies; compiled first

package esrl_pkg;

	localparam int BYTE_W       = 8;
	localparam int COUNT_W      = 10;
	localparam int MAX_CHANNELS = 512;
	localparam int INDEX_W      = $clog2(MAX_CHANNELS);
	localparam int SLOT_W       = INDEX_W + 1;

	typedef logic [BYTE_W-1:0]  rx_byte_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [SLOT_W-1:0]  slot_t;

	localparam rx_byte_t ESC_BYTE   = 8'h5C;
	localparam rx_byte_t SYNC_CODE  = 8'h00;
	localparam rx_byte_t SHELL_CODE = 8'h6D;

	localparam count_t COUNT_RESET = COUNT_W'(MAX_CHANNELS);
	localparam count_t COUNT_MAX   = COUNT_W'(MAX_CHANNELS);

	typedef struct packed {
		logic  in_frame;
		logic  escape_pending;
		slot_t next_index;
	} state_t;

	typedef struct packed {
		logic     write_enable;
		index_t   write_index;
		rx_byte_t write_value;
		logic     shell_exit;
		logic     frame_full;
	} result_t;

endpackage

// File: sv/esrl_ifs.sv
// esrl_byte_if and esrl_write_if: valid/ready channels of the register loader
// depends on esrl_pkg

interface esrl_byte_if;
	logic              valid;
	logic              ready;
	esrl_pkg::rx_byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface esrl_write_if;
	logic               valid;
	logic               ready;
	logic               write_enable;
	esrl_pkg::index_t   write_index;
	esrl_pkg::rx_byte_t write_value;
	logic               shell_exit;
	logic               frame_full;

	modport source (
		output valid, output write_enable, output write_index, output write_value,
		output shell_exit, output frame_full, input ready
	);
	modport sink (
		input valid, input write_enable, input write_index, input write_value,
		input shell_exit, input frame_full, output ready
	);
endinterface

// File: sv/esrl_decode.sv
// esrl_decode: next-state and result logic for one received byte
// depends on esrl_pkg

module esrl_decode (
	input  esrl_pkg::state_t   state,
	input  esrl_pkg::rx_byte_t rx_byte,
	input  esrl_pkg::count_t   channel_count,
	output esrl_pkg::state_t   state_d,
	output esrl_pkg::result_t  result
);

	esrl_pkg::count_t   limit;
	esrl_pkg::slot_t    bumped;
	logic               accept;
	logic               store_en;
	esrl_pkg::rx_byte_t store_val;

	// counts above the channel maximum clamp to it
	assign limit  = (channel_count > esrl_pkg::COUNT_MAX) ? esrl_pkg::COUNT_MAX : channel_count;
	assign accept = state.in_frame && (esrl_pkg::COUNT_W'(state.next_index) < limit);
	assign bumped = state.next_index + esrl_pkg::SLOT_W'(1);

	always_comb begin
		state_d   = state;
		result    = '0;
		store_en  = 1'b0;
		store_val = rx_byte;
		if (!state.escape_pending) begin
			if (rx_byte == esrl_pkg::ESC_BYTE) begin
				state_d.escape_pending = 1'b1;
			end else begin
				store_en = 1'b1;
			end
		end else begin
			state_d.escape_pending = 1'b0;
			case (rx_byte)
				esrl_pkg::SYNC_CODE: begin
					state_d.next_index = '0;
					state_d.in_frame   = 1'b1;
				end
				esrl_pkg::SHELL_CODE: begin
					result.shell_exit  = 1'b1;
					state_d.next_index = '0;
					state_d.in_frame   = 1'b0;
				end
				esrl_pkg::ESC_BYTE: begin
					store_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (store_en && accept) begin
			result.write_enable = 1'b1;
			result.write_index  = state.next_index[esrl_pkg::INDEX_W-1:0];
			result.write_value  = store_val;
			state_d.next_index  = bumped;
			// last channel written, sync drops
			if (esrl_pkg::COUNT_W'(bumped) >= limit) begin
				result.frame_full = 1'b1;
				state_d.in_frame  = 1'b0;
			end
		end
	end

endmodule

// File: sv/escaped_serial_register_loader_top.sv
// escaped_serial_register_loader_top: escape-framed byte stream to register writes
// depends on esrl_pkg, esrl_ifs (esrl_byte_if, esrl_write_if) and esrl_decode
//
// usage
//   rx carries one received byte per item; res carries one result item per byte:
//   a register write (write_enable, write_index, write_value), a shell request
//   (shell_exit) and frame_full on the write that fills the last channel.
//   bytes that write nothing and request no shell exit still give an item with all flags low.
//   cfg_we / cfg_wdata load channel_count (registers per frame); write it only
//   while no item is in flight. counts above the channel maximum clamp to it.
// timing
//   an accepted item is registered in the input stage, decoded combinationally and
//   registered in the result register, which drives res valid. one item per cycle
//   sustained while res.ready stays high; the decoder state updates as each byte
//   leaves the input stage, so bytes follow each other back to back.
// reset
//   arst_n low clears both stages, drops sync, clears the pending escape and the
//   write index, and sets channel_count to the maximum.
// stalls
//   while res.ready is low the result register holds; one more byte can sit in
//   the input stage, then rx.ready falls until res drains. nothing is lost.

module escaped_serial_register_loader_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  esrl_pkg::count_t      cfg_wdata,
	esrl_byte_if.sink             rx,
	esrl_write_if.source          res
);

	// configuration
	esrl_pkg::count_t   channel_count_q;

	// input stage
	logic               valid_s1;
	esrl_pkg::rx_byte_t byte_s1;

	// decoder state and result register
	esrl_pkg::state_t   state_q;
	esrl_pkg::state_t   state_d;
	esrl_pkg::result_t  result_d;
	logic               valid_s2;
	esrl_pkg::result_t  result_s2;

	logic               advance;

	// input stage moves when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= esrl_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			channel_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	esrl_decode u_decode (
		.state         (state_q),
		.rx_byte       (byte_s1),
		.channel_count (channel_count_q),
		.state_d       (state_d),
		.result        (result_d)
	);

	// decoder state advances only when the byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign res.valid        = valid_s2;
	assign res.write_enable = result_s2.write_enable;
	assign res.write_index  = result_s2.write_index;
	assign res.write_value  = result_s2.write_value;
	assign res.shell_exit   = result_s2.shell_exit;
	assign res.frame_full   = result_s2.frame_full;

endmodule

// File: sv/esrl_checker.sv
// esrl_checker: port-level assertions for the register loader, bound to the top level
// depends on esrl_pkg and escaped_serial_register_loader_top

module esrl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               write_enable,
	input esrl_pkg::index_t   write_index,
	input esrl_pkg::rx_byte_t write_value,
	input logic               shell_exit,
	input logic               frame_full
);

	logic             res_take;
	logic             last_valid_q;
	logic             last_full_q;
	esrl_pkg::index_t last_index_q;

	assign res_take = res_valid && res_ready;

	// last write index seen, forgotten on a shell request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_full_q  <= 1'b0;
			last_index_q <= '0;
		end else if (res_take && write_enable) begin
			last_valid_q <= 1'b1;
			last_full_q  <= frame_full;
			last_index_q <= write_index;
		end else if (res_take && shell_exit) begin
			last_valid_q <= 1'b0;
		end
	end

	// writes go to successive indices unless a new frame restarts at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		res_take && write_enable && (write_index != '0) |->
			last_valid_q && !last_full_q &&
			(write_index == last_index_q + esrl_pkg::INDEX_W'(1)))
		else $error("write index skipped or written after frame end");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && shell_exit |-> !write_enable)
		else $error("shell request together with a write");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_full |-> write_enable)
		else $error("frame full without a write");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(write_enable) &&
			$stable(write_index) && $stable(write_value) &&
			$stable(shell_exit) && $stable(frame_full))
		else $error("stalled result item changed");

endmodule

bind escaped_serial_register_loader_top esrl_checker u_esrl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.write_enable (res.write_enable),
	.write_index  (res.write_index),
	.write_value  (res.write_value),
	.shell_exit   (res.shell_exit),
	.frame_full   (res.frame_full)
);
